>>> rtl/dual_contact_key_velocity_scanner_assert.svh
// Assertion macros shared by the key velocity scanner modules.
`ifndef DUAL_CONTACT_KEY_VELOCITY_SCANNER_ASSERT_SVH
`define DUAL_CONTACT_KEY_VELOCITY_SCANNER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DCKVS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dckvs assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define DCKVS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dckvs assertion failed");

`endif

>>> rtl/dckvs_pkg.sv
// Shared types and constants of the key velocity scanner.
package dckvs_pkg;

   localparam int unsigned KEY_W      = 5;
   localparam int unsigned NOW_W      = 32;
   localparam int unsigned NOTE_W     = 8;
   localparam int unsigned VEL_W      = 14;
   localparam int unsigned SHIFT_W    = 2;
   localparam int unsigned VEL_MAX    = 9999;

   localparam int unsigned NUM_KEYS_DEF = 32;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_NOTE_BASE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_SHIFT = CSR_IDX_W'(1);

   localparam logic [NOTE_W-1:0]  NOTE_BASE_RST = NOTE_W'(150);
   localparam logic [SHIFT_W-1:0] VEL_SHIFT_RST = SHIFT_W'(1);

   // One key event handed from the classifier to the formatter.
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             note_off;
      logic [NOW_W-1:0] elapsed;
   } event_type;

endpackage

>>> rtl/dckvs_front.sv
// Front end: accepts contact samples, keeps per-key phase and press time, emits key events.
module dckvs_front #(
   parameter int unsigned NUM_KEYS = dckvs_pkg::NUM_KEYS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [dckvs_pkg::KEY_W-1:0]      req_key,
   input  logic                             req_contact,
   input  logic                             req_closed,
   input  logic [dckvs_pkg::NOW_W-1:0]      req_now,
   input  logic [dckvs_pkg::QCNT_W-1:0]     q_count,
   output logic                             push,
   output dckvs_pkg::event_type             push_event
);

   localparam int unsigned IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int unsigned EXT_W = dckvs_pkg::KEY_W + IDX_W;
   localparam int unsigned CNT_W = dckvs_pkg::QCNT_W;
   localparam int unsigned NOW_W = dckvs_pkg::NOW_W;

   typedef enum logic [1:0] {
      PHASE_IDLE     = 2'd0,
      PHASE_HALF     = 2'd1,
      PHASE_SOUNDING = 2'd2
   } phase_type;

   phase_type               phase_mem_ff [NUM_KEYS];
   logic [NOW_W-1:0]        time_mem_ff  [NUM_KEYS];
   logic [NUM_KEYS-1:0]     phase_vld_ff;

   logic                    accept;
   logic [EXT_W-1:0]        key_ext;
   logic                    in_range;
   logic [IDX_W-1:0]        rd_idx;
   logic [CNT_W:0]          stall_sum;

   logic                    s1_valid_ff;
   logic [IDX_W-1:0]        s1_idx_ff;
   logic [dckvs_pkg::KEY_W-1:0] s1_key_ff;
   logic                    s1_second_ff;
   logic                    s1_closed_ff;
   logic [NOW_W-1:0]        s1_now_ff;
   phase_type               phase_rd_ff;
   logic                    vld_rd_ff;
   logic [NOW_W-1:0]        time_rd_ff;
   logic                    phase_fwd_ff;
   phase_type               phase_fwd_data_ff;
   logic                    time_fwd_ff;
   logic [NOW_W-1:0]        time_fwd_data_ff;

   phase_type               cur_phase;
   logic [NOW_W-1:0]        cur_time;
   logic                    phase_we;
   phase_type               phase_wdata;
   logic                    time_we;

   // The queue must have room for the item in execute and the one accepted now.
   assign stall_sum = {1'b0, q_count} + (CNT_W + 1)'(s1_valid_ff);
   assign req_stall = stall_sum >= (CNT_W + 1)'(dckvs_pkg::QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;

   assign key_ext  = {{IDX_W{1'b0}}, req_key};
   assign in_range = key_ext < EXT_W'(NUM_KEYS);
   assign rd_idx   = key_ext[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         phase_vld_ff <= '0;
      end else begin
         s1_valid_ff <= accept && in_range;
         if (phase_we) begin
            phase_vld_ff[s1_idx_ff] <= 1'b1;
         end
      end
   end

   // Registered reads; a write to the same key in this cycle is forwarded.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff         <= rd_idx;
         s1_key_ff         <= req_key;
         s1_second_ff      <= req_contact;
         s1_closed_ff      <= req_closed;
         s1_now_ff         <= req_now;
         phase_rd_ff       <= phase_mem_ff[rd_idx];
         vld_rd_ff         <= phase_vld_ff[rd_idx];
         time_rd_ff        <= time_mem_ff[rd_idx];
         phase_fwd_ff      <= phase_we && (s1_idx_ff == rd_idx);
         phase_fwd_data_ff <= phase_wdata;
         time_fwd_ff       <= time_we && (s1_idx_ff == rd_idx);
         time_fwd_data_ff  <= s1_now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (phase_we) begin
         phase_mem_ff[s1_idx_ff] <= phase_wdata;
      end
      if (time_we) begin
         time_mem_ff[s1_idx_ff] <= s1_now_ff;
      end
   end

   // The press time is read only in the half-pressed phase, which is entered
   // only together with a write of the time, so it needs no clearing.
   always_comb begin
      if (phase_fwd_ff) begin
         cur_phase = phase_fwd_data_ff;
      end else if (vld_rd_ff) begin
         cur_phase = phase_rd_ff;
      end else begin
         cur_phase = PHASE_IDLE;
      end
      cur_time = time_fwd_ff ? time_fwd_data_ff : time_rd_ff;
   end

   always_comb begin
      phase_we            = 1'b0;
      phase_wdata         = PHASE_IDLE;
      time_we             = 1'b0;
      push                = 1'b0;
      push_event.key      = s1_key_ff;
      push_event.note_off = 1'b0;
      push_event.elapsed  = s1_now_ff - cur_time;
      if (s1_valid_ff) begin
         if (!s1_second_ff) begin
            if (s1_closed_ff) begin
               if (cur_phase == PHASE_IDLE) begin
                  phase_we    = 1'b1;
                  phase_wdata = PHASE_HALF;
                  time_we     = 1'b1;
               end
            end else begin
               unique case (cur_phase)
                  PHASE_IDLE: begin
                  end
                  PHASE_HALF: begin
                     phase_we = 1'b1;
                  end
                  default: begin
                     // Sounding, and the unused fourth code, release the note.
                     phase_we            = 1'b1;
                     push                = 1'b1;
                     push_event.note_off = 1'b1;
                  end
               endcase
            end
         end else if (s1_closed_ff && (cur_phase == PHASE_HALF)) begin
            phase_we    = 1'b1;
            phase_wdata = PHASE_SOUNDING;
            push        = 1'b1;
         end
      end
   end

endmodule

>>> rtl/dckvs_queue.sv
// Short event queue between the front end and the output formatter.
module dckvs_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  dckvs_pkg::event_type          push_event,
   input  logic                          pop,
   output logic                          not_empty,
   output dckvs_pkg::event_type          head_event,
   output logic [dckvs_pkg::QCNT_W-1:0]  count
);

`include "dual_contact_key_velocity_scanner_assert.svh"

   localparam int unsigned DEPTH = dckvs_pkg::QUEUE_DEPTH;
   localparam int unsigned PTR_W = dckvs_pkg::QPTR_W;
   localparam int unsigned CNT_W = dckvs_pkg::QCNT_W;

   dckvs_pkg::event_type  entry_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff;
   logic [PTR_W-1:0]      rd_ptr_ff;
   logic [CNT_W-1:0]      count_ff;

   assign not_empty  = count_ff != '0;
   assign head_event = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_event;
      end
   end

   `DCKVS_ASSERT_IMPL(a_no_overflow, clock, reset, push, count_ff < CNT_W'(DEPTH))
   `DCKVS_ASSERT_IMPL(a_no_underflow, clock, reset, pop, count_ff != '0)

endmodule

>>> rtl/dckvs_back.sv
// Back end: turns queued key events into note and velocity results in the output register.
module dckvs_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            not_empty,
   input  dckvs_pkg::event_type            head_event,
   output logic                            pop,
   input  logic [dckvs_pkg::NOTE_W-1:0]    note_base,
   input  logic [dckvs_pkg::SHIFT_W-1:0]   velocity_shift,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [dckvs_pkg::NOTE_W-1:0]    rsp_note,
   output logic                            rsp_note_off,
   output logic [dckvs_pkg::VEL_W-1:0]     rsp_velocity
);

`include "dual_contact_key_velocity_scanner_assert.svh"

   localparam int unsigned NOTE_W = dckvs_pkg::NOTE_W;
   localparam int unsigned VEL_W  = dckvs_pkg::VEL_W;
   localparam int unsigned NOW_W  = dckvs_pkg::NOW_W;

   logic                  rsp_valid_ff;
   logic [NOTE_W-1:0]     rsp_note_ff;
   logic                  rsp_note_off_ff;
   logic [VEL_W-1:0]      rsp_velocity_ff;

   logic [NOW_W-1:0]      shifted;
   logic [VEL_W-1:0]      velocity_in;
   logic [NOTE_W-1:0]     note_in;

   assign pop = not_empty && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      shifted = head_event.elapsed >> velocity_shift;
      if (head_event.note_off) begin
         velocity_in = '0;
      end else if (shifted > NOW_W'(dckvs_pkg::VEL_MAX)) begin
         velocity_in = VEL_W'(dckvs_pkg::VEL_MAX);
      end else begin
         velocity_in = shifted[VEL_W-1:0];
      end
      note_in = note_base - NOTE_W'(head_event.key);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_note_ff     <= note_in;
         rsp_note_off_ff <= head_event.note_off;
         rsp_velocity_ff <= velocity_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_note     = rsp_note_ff;
   assign rsp_note_off = rsp_note_off_ff;
   assign rsp_velocity = rsp_velocity_ff;

   `DCKVS_ASSERT_IMPL(a_vel_limit, clock, reset, rsp_valid_ff, rsp_velocity_ff <= VEL_W'(dckvs_pkg::VEL_MAX))
   `DCKVS_ASSERT_IMPL(a_off_zero_vel, clock, reset, rsp_valid_ff && rsp_note_off_ff, rsp_velocity_ff == '0)

endmodule

>>> rtl/dual_contact_key_velocity_scanner.sv
// Top level of the dual-contact key velocity scanner.
//
// The req channel takes one contact sample per transaction: key, contact
// (first or second), closed and the current tick count. The rsp channel
// gives note on and note off events with note number and velocity; most
// samples produce no event. Both channels use valid and stall, and a
// transaction completes when valid is high and stall is low.
// The csr port writes note_base (index 0) and velocity_shift (index 1);
// the user must write them only while the block is idle, as the block
// itself leaves this unchecked. They reset to 150 and 1. A sample is
// registered, then classified and its key entry updated; its event is
// queued, then registered for output. One sample is taken every cycle
// while req_stall is low, set by the single read-modify-write of the
// key phase store, with same-key updates forwarded between adjacent
// samples. Reset returns every key to idle through per-key valid bits
// at once. When the receiver stalls, events collect in a four-entry
// queue and req_stall rises once that queue cannot absorb another event.
module dual_contact_key_velocity_scanner #(
   parameter int unsigned NUM_KEYS = dckvs_pkg::NUM_KEYS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [dckvs_pkg::KEY_W-1:0]         req_key,
   input  logic                                req_contact,
   input  logic                                req_closed,
   input  logic [dckvs_pkg::NOW_W-1:0]         req_now,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [dckvs_pkg::NOTE_W-1:0]        rsp_note,
   output logic                                rsp_note_off,
   output logic [dckvs_pkg::VEL_W-1:0]         rsp_velocity,
   input  logic                                csr_write,
   input  logic [dckvs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dckvs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [dckvs_pkg::NOTE_W-1:0]   note_base_ff;
   logic [dckvs_pkg::SHIFT_W-1:0]  velocity_shift_ff;

   logic                           push;
   dckvs_pkg::event_type           push_event;
   logic                           pop;
   logic                           not_empty;
   dckvs_pkg::event_type           head_event;
   logic [dckvs_pkg::QCNT_W-1:0]   q_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         note_base_ff      <= dckvs_pkg::NOTE_BASE_RST;
         velocity_shift_ff <= dckvs_pkg::VEL_SHIFT_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            dckvs_pkg::CSR_NOTE_BASE: begin
               note_base_ff <= csr_wdata[dckvs_pkg::NOTE_W-1:0];
            end
            dckvs_pkg::CSR_VEL_SHIFT: begin
               velocity_shift_ff <= csr_wdata[dckvs_pkg::SHIFT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   dckvs_front #(
      .NUM_KEYS (NUM_KEYS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_key     (req_key),
      .req_contact (req_contact),
      .req_closed  (req_closed),
      .req_now     (req_now),
      .q_count     (q_count),
      .push        (push),
      .push_event  (push_event)
   );

   dckvs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_event (push_event),
      .pop        (pop),
      .not_empty  (not_empty),
      .head_event (head_event),
      .count      (q_count)
   );

   dckvs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .not_empty      (not_empty),
      .head_event     (head_event),
      .pop            (pop),
      .note_base      (note_base_ff),
      .velocity_shift (velocity_shift_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_note       (rsp_note),
      .rsp_note_off   (rsp_note_off),
      .rsp_velocity   (rsp_velocity)
   );

endmodule
